### rtl/sri_pkg.sv
// ----------------------------------------------------------------------------
// sri_pkg
// Shared types and constants for the snapshot ring index block.
// ----------------------------------------------------------------------------
package sri_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] OP_PUBLISH = 2'd0;
  localparam logic [1:0] OP_NEAREST = 2'd1;
  localparam logic [1:0] OP_FRAME   = 2'd2;

  // Field widths of one input and one result item.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 280;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch the input request and clear the search result
    logic publish;   // perform the publish update
    logic scan_step; // read the next ring entry for the search
    logic rd_old;    // read the oldest entry
    logic rd_new;    // read the newest entry
    logic load;      // load the result register
  } sri_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan_done;
    logic            out_stall;
  } sri_status_t;

endpackage

### rtl/sri_ctrl.sv
// ----------------------------------------------------------------------------
// sri_ctrl
// Sequencer for the snapshot ring index: dispatches requests, runs the publish
// update or ring scan, fetches the oldest and newest tags, loads the result.
// ----------------------------------------------------------------------------
module sri_ctrl
  import sri_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sri_status_t status_i,
  output sri_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_PUB  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_OLD  = 3'd4;
  localparam logic [2:0] ST_NEW  = 3'd5;
  localparam logic [2:0] ST_WAIT = 3'd6;
  localparam logic [2:0] ST_LOAD = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DISP;
        end
      end
      ST_DISP: begin
        case (status_i.op)
          OP_PUBLISH: state_d = ST_PUB;
          OP_NEAREST: state_d = ST_SCAN;
          OP_FRAME:   state_d = ST_SCAN;
          default:    state_d = ST_OLD;
        endcase
      end
      ST_PUB: begin
        cmd_o.publish = 1'b1;
        state_d       = ST_OLD;
      end
      ST_SCAN: begin
        // The last read returns in the cycle that the scan finishes.
        if (status_i.scan_done) begin
          state_d = ST_OLD;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_OLD: begin
        cmd_o.rd_old = 1'b1;
        state_d      = ST_NEW;
      end
      ST_NEW: begin
        cmd_o.rd_new = 1'b1;
        state_d      = ST_WAIT;
      end
      ST_WAIT: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (!status_i.out_stall) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/sri_dp.sv
// ----------------------------------------------------------------------------
// sri_dp
// Datapath of the snapshot ring index: tag memory, ring pointers, scan
// comparator, captured oldest and newest tags and the result register.
// ----------------------------------------------------------------------------
module sri_dp
  import sri_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sri_cmd_t              cmd_i,
  output sri_status_t           status_o,
  input  logic [OP_W-1:0]       in_op_i,
  input  logic [STAMP_W-1:0]    in_cycle_i,
  input  logic [FRAME_W-1:0]    in_frame_i,
  input  logic                  in_write_ok_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned PW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned ENT_W = STAMP_W + FRAME_W;

  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_SCAN = 2'd1;
  localparam logic [1:0] RD_OLD  = 2'd2;
  localparam logic [1:0] RD_NEW  = 2'd3;

  // Latched request.
  logic [OP_W-1:0]    op_q;
  logic [STAMP_W-1:0] cycle_q;
  logic [FRAME_W-1:0] frame_q;
  logic               ok_q;

  // Ring state.
  logic [PW-1:0] optr_q, optr_d;
  logic [CW-1:0] count_q, count_d;

  // Scan state and search result.
  logic [PW-1:0]      scan_ptr_q;
  logic [CW-1:0]      scan_cnt_q;
  logic               hit_q;
  logic [PW-1:0]      sel_slot_q;
  logic [STAMP_W-1:0] sel_cycle_q;

  // Memory port.
  logic [ENT_W-1:0] mem_q [SLOTS];
  logic [ENT_W-1:0] rd_data_q;
  logic [PW-1:0]    rd_pos_q;
  logic [1:0]       rd_kind_q, rd_kind_d;
  logic [PW-1:0]    rd_addr;
  logic             wr_en;
  logic [PW-1:0]    wr_addr;

  logic [STAMP_W-1:0] rd_stamp;
  logic [FRAME_W-1:0] rd_frame;

  // Captured oldest and newest tags.
  logic [STAMP_W-1:0] old_stamp_q, new_stamp_q;
  logic [FRAME_W-1:0] old_frame_q, new_frame_q;

  // Result register.
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // Ring position arithmetic.
  logic [CW:0]   tail_sum, newest_sum;
  logic [PW-1:0] tail_pos, newest_pos, optr_inc, scan_inc;
  logic          full;

  assign full = (count_q >= CW'(SLOTS));

  always_comb begin
    tail_sum = (CW+1)'(optr_q) + (CW+1)'(count_q);
    if (tail_sum >= (CW+1)'(SLOTS)) begin
      tail_sum = tail_sum - (CW+1)'(SLOTS);
    end
    tail_pos = tail_sum[PW-1:0];

    newest_sum = (CW+1)'(optr_q) + (CW+1)'(count_q) - (CW+1)'(1);
    if (newest_sum >= (CW+1)'(SLOTS)) begin
      newest_sum = newest_sum - (CW+1)'(SLOTS);
    end
    newest_pos = newest_sum[PW-1:0];

    optr_inc = (optr_q == PW'(SLOTS - 1)) ? '0 : optr_q + PW'(1);
    scan_inc = (scan_ptr_q == PW'(SLOTS - 1)) ? '0 : scan_ptr_q + PW'(1);
  end

  // Publish update of the ring pointers.
  always_comb begin
    optr_d  = optr_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = full ? optr_q : tail_pos;
    if (cmd_i.publish && (op_q == OP_PUBLISH)) begin
      if (ok_q) begin
        wr_en = 1'b1;
        if (full) begin
          optr_d = optr_inc;
        end else begin
          count_d = count_q + CW'(1);
        end
      end else if (full) begin
        optr_d  = optr_inc;
        count_d = count_q - CW'(1);
      end
    end
  end

  // Read address and the tag that goes with the returning data.
  always_comb begin
    rd_kind_d = RD_NONE;
    rd_addr   = scan_ptr_q;
    if (cmd_i.scan_step) begin
      rd_kind_d = RD_SCAN;
    end else if (cmd_i.rd_old) begin
      rd_kind_d = RD_OLD;
      rd_addr   = optr_q;
    end else if (cmd_i.rd_new) begin
      rd_kind_d = RD_NEW;
      rd_addr   = newest_pos;
    end
  end

  // Tag memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {frame_q, cycle_q};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign rd_stamp = rd_data_q[STAMP_W-1:0];
  assign rd_frame = rd_data_q[ENT_W-1:STAMP_W];

  // Request latch and captured tags (no reset needed).
  always_ff @(posedge clk_i) begin
    rd_pos_q <= rd_addr;
    if (cmd_i.accept) begin
      op_q    <= in_op_i;
      cycle_q <= in_cycle_i;
      frame_q <= in_frame_i;
      ok_q    <= in_write_ok_i;
    end
    if (rd_kind_q == RD_OLD) begin
      old_stamp_q <= rd_stamp;
      old_frame_q <= rd_frame;
    end
    if (rd_kind_q == RD_NEW) begin
      new_stamp_q <= rd_stamp;
      new_frame_q <= rd_frame;
    end
  end

  // Control registers: ring pointers, scan progress and search result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      optr_q      <= '0;
      count_q     <= '0;
      scan_ptr_q  <= '0;
      scan_cnt_q  <= '0;
      hit_q       <= 1'b0;
      sel_slot_q  <= '0;
      sel_cycle_q <= '0;
      rd_kind_q   <= RD_NONE;
    end else begin
      optr_q    <= optr_d;
      count_q   <= count_d;
      rd_kind_q <= rd_kind_d;
      if (cmd_i.accept) begin
        scan_ptr_q <= optr_q;
        scan_cnt_q <= '0;
        hit_q      <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_ptr_q <= scan_inc;
        scan_cnt_q <= scan_cnt_q + CW'(1);
      end
      // A publish reports the slot it wrote.
      if (cmd_i.publish && (op_q == OP_PUBLISH) && ok_q) begin
        hit_q       <= 1'b1;
        sel_slot_q  <= wr_addr;
        sel_cycle_q <= cycle_q;
      end
      // Nearest keeps the last match in age order; frame keeps the first.
      if (rd_kind_q == RD_SCAN) begin
        if ((op_q == OP_NEAREST) && (rd_stamp <= cycle_q)) begin
          hit_q       <= 1'b1;
          sel_slot_q  <= rd_pos_q;
          sel_cycle_q <= rd_stamp;
        end else if ((op_q == OP_FRAME) && (rd_frame == frame_q) && !hit_q) begin
          hit_q       <= 1'b1;
          sel_slot_q  <= rd_pos_q;
          sel_cycle_q <= rd_stamp;
        end
      end
    end
  end

  // Result assembly.
  logic               r_found;
  logic [PW-1:0]      r_slot;
  logic [STAMP_W-1:0] r_cycle;
  logic               empty;

  assign empty = (count_q == '0);

  always_comb begin
    r_found = hit_q;
    r_slot  = hit_q ? sel_slot_q : '0;
    r_cycle = hit_q ? sel_cycle_q : '1;
    // A nearest query with no match falls back to the oldest entry.
    if ((op_q == OP_NEAREST) && !hit_q && !empty) begin
      r_found = 1'b1;
      r_slot  = optr_q;
      r_cycle = old_stamp_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= {6'd0,
                     empty ? {FRAME_W{1'b0}} : new_frame_q,
                     empty ? {FRAME_W{1'b0}} : old_frame_q,
                     empty ? {STAMP_W{1'b0}} : new_stamp_q,
                     empty ? {STAMP_W{1'b0}} : old_stamp_q,
                     COUNT_W'(count_q),
                     r_cycle,
                     SLOT_W'(r_slot),
                     r_found};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o.op        = op_q;
  assign status_o.scan_done = (scan_cnt_q == count_q);
  assign status_o.out_stall = out_valid_q && !out_ready_i;

endmodule

### rtl/snapshot_ring_index_core.sv
// ----------------------------------------------------------------------------
// snapshot_ring_index_core
// Ring of snapshot tags (cycle stamp and frame number) that overwrites the
// oldest entry when full, with nearest-stamp and frame-number lookup.
// ----------------------------------------------------------------------------
// One request is handled at a time. A publish passes through dispatch, the
// publish update, reads of the oldest and newest tags and a wait state before
// the result register is loaded; op 3 skips the publish update. A nearest or
// frame query sweeps the single read port of the tag memory once over the
// stored entries, one entry per cycle, before those tag reads. A finished
// result sits in an output register, so the next request is taken while it
// waits. The tag memory needs no clearing after reset.
module snapshot_ring_index_core
  import sri_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: cycle[63:0], frame_number[95:64], write_ok[96], zero fill.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: op[1:0].
  input  logic [OP_W-1:0]       s_axis_tuser,
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: found[0], slot[8:1], cycle_out[72:9], entry_count[81:73],
  // oldest_cycle[145:82], newest_cycle[209:146], oldest_frame[241:210],
  // newest_frame[273:242], zero fill.
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  sri_cmd_t    cmd;
  sri_status_t status;

  // Sequencer.
  sri_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Tag memory and result datapath.
  sri_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_op_i       (s_axis_tuser),
    .in_cycle_i    (s_axis_tdata[STAMP_W-1:0]),
    .in_frame_i    (s_axis_tdata[STAMP_W+FRAME_W-1:STAMP_W]),
    .in_write_ok_i (s_axis_tdata[STAMP_W+FRAME_W]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_data_o    (m_axis_tdata)
  );

endmodule

### sim/snapshot_ring_index_checker.sv
// ----------------------------------------------------------------------------
// snapshot_ring_index_checker
// Watches both streams of the snapshot ring index, predicts each result from
// its own copy of the tag ring, and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module snapshot_ring_index_checker
  import sri_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [IN_DATA_W-1:0]  s_data_i,
  input  logic [OP_W-1:0]       s_user_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [OUT_DATA_W-1:0] m_data_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    overwrites_o,
  output int                    drops_o
);

  localparam int unsigned RING_SLOTS = 256;

  // Bit positions of the result fields, lowest field first.
  localparam int unsigned SLOT_LSB      = 1;
  localparam int unsigned STAMP_LSB     = SLOT_LSB + SLOT_W;
  localparam int unsigned COUNT_LSB     = STAMP_LSB + STAMP_W;
  localparam int unsigned OLD_STAMP_LSB = COUNT_LSB + COUNT_W;
  localparam int unsigned NEW_STAMP_LSB = OLD_STAMP_LSB + STAMP_W;
  localparam int unsigned OLD_FRAME_LSB = NEW_STAMP_LSB + STAMP_W;
  localparam int unsigned NEW_FRAME_LSB = OLD_FRAME_LSB + FRAME_W;
  localparam int unsigned FILL_LSB      = NEW_FRAME_LSB + FRAME_W;

  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [STAMP_W-1:0] stamp;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] oldest_stamp;
    logic [STAMP_W-1:0] newest_stamp;
    logic [FRAME_W-1:0] oldest_frame;
    logic [FRAME_W-1:0] newest_frame;
  } ring_result_t;

  // Predicted ring contents.
  logic [STAMP_W-1:0] stamp_mem [RING_SLOTS];
  logic [FRAME_W-1:0] frame_mem [RING_SLOTS];
  logic [SLOT_W-1:0]  head;
  logic [COUNT_W-1:0] live_count;

  ring_result_t expected_q [$];

  // Prints one line for a mismatch and counts it.
  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("[%0t] %s: got %h, wanted %h", $time, what, got, want);
    mismatches_o++;
  endtask

  // Applies one request to the predicted ring and returns its result.
  function automatic ring_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [STAMP_W-1:0] stamp,
                                                 input logic [FRAME_W-1:0] frame,
                                                 input logic ok);
    ring_result_t res;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] best;
    logic full;
    res = '0;
    res.stamp = '1;
    case (op)
      OP_PUBLISH: begin
        full = (live_count == COUNT_W'(RING_SLOTS));
        wr_slot = full ? head : head + live_count[SLOT_W-1:0];
        if (ok) begin
          stamp_mem[wr_slot] = stamp;
          frame_mem[wr_slot] = frame;
          if (full) begin
            head = head + SLOT_W'(1);
            overwrites_o++;
          end else begin
            live_count = live_count + COUNT_W'(1);
          end
          res.found = 1'b1;
          res.slot = wr_slot;
          res.stamp = stamp;
        end else if (full) begin
          // The aborted write has destroyed the oldest tag.
          head = head + SLOT_W'(1);
          live_count = live_count - COUNT_W'(1);
          drops_o++;
        end
      end
      OP_NEAREST: begin
        if (live_count != '0) begin
          best = head;
          for (int i = 0; i < int'(live_count); i++) begin
            pos = head + i[SLOT_W-1:0];
            if (stamp_mem[pos] <= stamp) begin
              best = pos;
            end
          end
          res.found = 1'b1;
          res.slot = best;
          res.stamp = stamp_mem[best];
        end
      end
      OP_FRAME: begin
        for (int i = 0; i < int'(live_count); i++) begin
          pos = head + i[SLOT_W-1:0];
          if (!res.found && frame_mem[pos] == frame) begin
            res.found = 1'b1;
            res.slot = pos;
            res.stamp = stamp_mem[pos];
          end
        end
      end
      default: begin
        // The unused operation leaves the ring alone and reports a miss.
      end
    endcase
    res.count = live_count;
    if (live_count != '0) begin
      pos = head + live_count[SLOT_W-1:0] - SLOT_W'(1);
      res.oldest_stamp = stamp_mem[head];
      res.newest_stamp = stamp_mem[pos];
      res.oldest_frame = frame_mem[head];
      res.newest_frame = frame_mem[pos];
    end
    return res;
  endfunction

  // Compares one result with the oldest prediction.
  task automatic check_result(input logic [OUT_DATA_W-1:0] got);
    ring_result_t want;
    if (expected_q.size() == 0) begin
      note_mismatch("result with no request pending", got[63:0], '0);
      return;
    end
    want = expected_q.pop_front();
    checked_o++;
    if (got[0] !== want.found)
      note_mismatch("found", 64'(got[0]), 64'(want.found));
    if (got[SLOT_LSB +: SLOT_W] !== want.slot)
      note_mismatch("slot", 64'(got[SLOT_LSB +: SLOT_W]), 64'(want.slot));
    if (got[STAMP_LSB +: STAMP_W] !== want.stamp)
      note_mismatch("cycle_out", got[STAMP_LSB +: STAMP_W], want.stamp);
    if (got[COUNT_LSB +: COUNT_W] !== want.count)
      note_mismatch("entry_count", 64'(got[COUNT_LSB +: COUNT_W]), 64'(want.count));
    if (got[OLD_STAMP_LSB +: STAMP_W] !== want.oldest_stamp)
      note_mismatch("oldest_cycle", got[OLD_STAMP_LSB +: STAMP_W], want.oldest_stamp);
    if (got[NEW_STAMP_LSB +: STAMP_W] !== want.newest_stamp)
      note_mismatch("newest_cycle", got[NEW_STAMP_LSB +: STAMP_W], want.newest_stamp);
    if (got[OLD_FRAME_LSB +: FRAME_W] !== want.oldest_frame)
      note_mismatch("oldest_frame", 64'(got[OLD_FRAME_LSB +: FRAME_W]),
                    64'(want.oldest_frame));
    if (got[NEW_FRAME_LSB +: FRAME_W] !== want.newest_frame)
      note_mismatch("newest_frame", 64'(got[NEW_FRAME_LSB +: FRAME_W]),
                    64'(want.newest_frame));
    if (got[OUT_DATA_W-1:FILL_LSB] !== '0)
      note_mismatch("zero fill", 64'(got[OUT_DATA_W-1:FILL_LSB]), '0);
  endtask

  initial begin
    mismatches_o = 0;
    pending_o = 0;
    checked_o = 0;
    overwrites_o = 0;
    drops_o = 0;
    head = '0;
    live_count = '0;
  end

  // Both streams are sampled at the rising edge, before the edge's updates land.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      head = '0;
      live_count = '0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        expected_q.push_back(apply_request(s_user_i, s_data_i[0 +: STAMP_W],
                                           s_data_i[STAMP_W +: FRAME_W],
                                           s_data_i[STAMP_W + FRAME_W]));
      end
      if (m_valid_i && m_ready_i) begin
        check_result(m_data_i);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### sim/snapshot_ring_index_core_tb.sv
// ----------------------------------------------------------------------------
// snapshot_ring_index_core_tb
// Drives publish and lookup requests into the snapshot ring index: a short
// directed sequence, a fill phase that wraps the ring, then a mixed phase on
// a full ring. Requests come in bursts and the result side stalls on its own
// pattern; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module snapshot_ring_index_core_tb;
  import sri_pkg::*;

  localparam logic [OP_W-1:0]    OP_UNUSED = 2'd3;
  localparam int unsigned        RUN_LIMIT = 1_000_000;
  localparam int unsigned        DRAIN_CYCLES = 300;
  localparam int unsigned        FILL_ITEMS = 290;
  localparam int unsigned        MIX_ITEMS = 160;
  localparam int unsigned        RECENT_DEPTH = 32;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_PERIODIC,
    READY_SPARSE
  } ready_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int mismatches;
  int pending;
  int checked;
  int overwrites;
  int drops;
  int cycle_count = 0;

  // Stimulus bookkeeping.
  logic [STAMP_W-1:0] stamp_clock;
  logic [FRAME_W-1:0] frame_clock;
  logic [STAMP_W-1:0] recent_stamps [$];
  logic [FRAME_W-1:0] recent_frames [$];
  int burst_left;
  int n_publish;
  int n_nearest;
  int n_frame;
  int n_unused;

  ready_mode_e ready_mode = READY_ALWAYS;
  int          ready_mode_left = 0;

  snapshot_ring_index_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  snapshot_ring_index_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked),
    .overwrites_o(overwrites),
    .drops_o     (drops)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Run limit reached with %0d results outstanding", pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // The result side switches at random between stall patterns.
  always @(posedge clk_i) begin
    if (ready_mode_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_mode_left <= $urandom_range(16, 96);
    end else begin
      ready_mode_left <= ready_mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS:   m_axis_tready <= 1'b1;
      READY_MOSTLY:   m_axis_tready <= ($urandom_range(0, 9) < 7);
      READY_PERIODIC: m_axis_tready <= (cycle_count[2:0] < 3'd3);
      default:        m_axis_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  function automatic logic [STAMP_W-1:0] rand_stamp();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [STAMP_W-1:0] recent_stamp();
    return recent_stamps[$urandom_range(0, recent_stamps.size() - 1)];
  endfunction

  function automatic logic [FRAME_W-1:0] recent_frame();
    return recent_frames[$urandom_range(0, recent_frames.size() - 1)];
  endfunction

  // Stamps mostly rise like an emulated cycle counter, with odd values mixed in.
  function automatic logic [STAMP_W-1:0] next_stamp();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return rand_stamp();
    if (roll < 10) return ($urandom_range(0, 1) != 0) ? STAMP_MAX : '0;
    if (roll < 15 && recent_stamps.size() != 0) return recent_stamp();
    stamp_clock = stamp_clock + STAMP_W'($urandom_range(1, 3000));
    return stamp_clock;
  endfunction

  function automatic logic [FRAME_W-1:0] next_frame();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return $urandom;
    if (roll < 16 && recent_frames.size() != 0) return recent_frame();
    frame_clock = frame_clock + FRAME_W'(1);
    return frame_clock;
  endfunction

  function automatic logic [STAMP_W-1:0] nearest_target();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35 && recent_stamps.size() != 0) return recent_stamp();
    if (roll < 55 && recent_stamps.size() != 0)
      return recent_stamp() + STAMP_W'($urandom_range(0, 4)) - 64'd2;
    if (roll < 70) return rand_stamp();
    if (roll < 80) return '0;
    if (roll < 85) return STAMP_MAX;
    return stamp_clock;
  endfunction

  function automatic logic [FRAME_W-1:0] frame_target();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60 && recent_frames.size() != 0) return recent_frame();
    if (roll < 75) return frame_clock + 32'd1000;
    return $urandom;
  endfunction

  // Presents one request in the current burst and waits for the handshake.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] stamp,
                           input logic [FRAME_W-1:0] frame, input logic ok);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= IN_DATA_W'({ok, frame, stamp});
    do @(posedge clk_i); while (!s_axis_tready);
    case (op)
      OP_PUBLISH: n_publish++;
      OP_NEAREST: n_nearest++;
      OP_FRAME:   n_frame++;
      default:    n_unused++;
    endcase
  endtask

  // Publishes a tag and remembers it so that later lookups can hit.
  task automatic publish_tag(input logic [STAMP_W-1:0] stamp,
                             input logic [FRAME_W-1:0] frame, input logic ok);
    send_item(OP_PUBLISH, stamp, frame, ok);
    if (ok) begin
      recent_stamps.push_back(stamp);
      recent_frames.push_back(frame);
      if (recent_stamps.size() > RECENT_DEPTH) begin
        void'(recent_stamps.pop_front());
        void'(recent_frames.pop_front());
      end
    end
  endtask

  task automatic random_item(input int unsigned publish_pct, input int unsigned ok_pct);
    int unsigned roll;
    int unsigned rest;
    roll = $urandom_range(0, 99);
    rest = 100 - publish_pct;
    if (roll < publish_pct)
      publish_tag(next_stamp(), next_frame(), $urandom_range(0, 99) < ok_pct);
    else if (roll < publish_pct + rest * 2 / 5)
      send_item(OP_NEAREST, nearest_target(), $urandom, 1'($urandom_range(0, 1)));
    else if (roll < publish_pct + rest * 4 / 5)
      send_item(OP_FRAME, rand_stamp(), frame_target(), 1'($urandom_range(0, 1)));
    else
      send_item(OP_UNUSED, rand_stamp(), $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Holds the request side idle until every result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    burst_left = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    stamp_clock = 64'd5000;
    frame_clock = 32'd100;
    burst_left = 0;
    n_publish = 0;
    n_nearest = 0;
    n_frame = 0;
    n_unused = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lookups, the unused operation and a failed publish on an empty ring.
    send_item(OP_NEAREST, 64'd1234, 32'd0, 1'b1);
    send_item(OP_FRAME, '0, 32'd0, 1'b0);
    send_item(OP_UNUSED, STAMP_MAX, FRAME_MAX, 1'b1);
    publish_tag(64'd777, 32'd3, 1'b0);

    // A target below every stamp falls back to the oldest tag.
    publish_tag(64'd1000, 32'd7, 1'b1);
    send_item(OP_NEAREST, 64'd5, 32'd0, 1'b0);

    // Field extremes, a repeated frame number and a repeated stamp.
    publish_tag('0, '0, 1'b1);
    publish_tag(STAMP_MAX, FRAME_MAX, 1'b1);
    publish_tag(64'd2000, 32'd7, 1'b1);
    publish_tag(64'd1000, 32'd9, 1'b1);

    // Nearest lookups at and around the stored stamps.
    send_item(OP_NEAREST, '0, 32'd0, 1'b0);
    send_item(OP_NEAREST, 64'd999, 32'd0, 1'b0);
    send_item(OP_NEAREST, 64'd1000, 32'd0, 1'b0);
    send_item(OP_NEAREST, STAMP_MAX, FRAME_MAX, 1'b1);

    // Frame lookups: oldest of two matches, extremes and a miss.
    send_item(OP_FRAME, '0, 32'd7, 1'b0);
    send_item(OP_FRAME, '0, FRAME_MAX, 1'b0);
    send_item(OP_FRAME, STAMP_MAX, '0, 1'b1);
    send_item(OP_FRAME, '0, 32'd12345, 1'b0);

    // The unused operation and a failed publish on a partly filled ring.
    send_item(OP_UNUSED, '0, '0, 1'b0);
    publish_tag(64'd3000, 32'd11, 1'b0);
    wait_for_results();

    // Fill until the ring wraps, then mix operations on a full ring.
    repeat (FILL_ITEMS) random_item(95, 97);
    wait_for_results();
    repeat (MIX_ITEMS) random_item(50, 75);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d publishes, %0d nearest and %0d frame lookups, %0d unused ops.",
             n_publish, n_nearest, n_frame, n_unused);
    $display("Checked %0d results; %0d tags overwritten and %0d dropped on a full ring.",
             checked, overwrites, drops);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### snapshot_ring_index_core.f
rtl/sri_pkg.sv
rtl/sri_ctrl.sv
rtl/sri_dp.sv
rtl/snapshot_ring_index_core.sv
sim/snapshot_ring_index_checker.sv
sim/snapshot_ring_index_core_tb.sv
